/* rtl/patch_record_byte_encoder_core_macros.svh */
// ----------------------------------------------------------------------------
// Patch record byte encoder assertion macros
// Concurrent check helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PATCH_RECORD_BYTE_ENCODER_CORE_MACROS_SVH
`define PATCH_RECORD_BYTE_ENCODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PREC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PREC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PREC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define PREC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/prec_pkg.sv */
// ----------------------------------------------------------------------------
// Patch record byte encoder package
// Command codes, header constants and the encoded frame type.
// ----------------------------------------------------------------------------
package prec_pkg;

    localparam int unsigned MAX_BYTES = 5;
    localparam int unsigned CNT_W     = 3;

    localparam logic [1:0] CMD_DELETE = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_SUBST  = 2'd2;

    localparam logic [1:0] HDR_LONG_CODE = 2'b11;

    typedef logic [7:0]       byte_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        cnt_t                      cnt;
    } frame_t;

endpackage

/* rtl/patch_record_byte_encoder_core.sv */
// ----------------------------------------------------------------------------
// Patch record byte encoder core
// Encodes edit records into a byte stream of headers and data bytes.
// ----------------------------------------------------------------------------
// Input channel: one edit record per beat (edit_cmd, target_addr, new_byte,
// group_len) on in_valid/in_ready. Output channel: one byte per beat
// (out_byte, last_of_item) on out_valid/out_ready; last_of_item marks the
// final byte of a record. A record yields 0 to 5 bytes; records that yield
// none (delete or reserved command inside a group) produce no beat at all.
// The first byte of a record passes the encode register and then the
// serializer's byte buffer before it is presented on out_byte.
// The serializer sends one byte per cycle while out_ready is high; a
// finished frame waits in the encode register while the serializer drains,
// so intake continues during output until the encode register is full.
// Reset clears the previous address and the pending group count to zero and
// empties both stages. When the receiver stalls, the serializer holds its
// byte, the encode register fills, and in_ready drops until space frees.
// ----------------------------------------------------------------------------
`include "patch_record_byte_encoder_core_macros.svh"

module patch_record_byte_encoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  edit_cmd,
    input  logic [15:0] target_addr,
    input  logic [7:0]  new_byte,
    input  logic [7:0]  group_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_item
);

    logic              frame_vld;
    prec_pkg::frame_t  frame;
    logic              ser_ready;

    prec_encode u_encode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .edit_cmd    (edit_cmd),
        .target_addr (target_addr),
        .new_byte    (new_byte),
        .group_len   (group_len),
        .frame_vld   (frame_vld),
        .frame       (frame),
        .ser_ready   (ser_ready)
    );

    prec_serialize u_serialize
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_vld    (frame_vld),
        .frame        (frame),
        .ser_ready    (ser_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item)
    );

    `PREC_ASSERT_SAME(a_frame_cnt, clk, rst_n, frame_vld,
        (frame.cnt != 3'd0) && (frame.cnt <= 3'd5), "frame byte count out of range")
    `PREC_ASSERT_NEXT(a_frame_hold, clk, rst_n, frame_vld && !ser_ready, frame_vld,
        "pending frame lost")
    `PREC_ASSERT_NEXT(a_record_contig, clk, rst_n, out_valid && out_ready && !last_of_item,
        out_valid, "record byte stream broken")

endmodule

/* rtl/prec_encode.sv */
// ----------------------------------------------------------------------------
// Patch record encode stage
// Tracks address and group state, builds one record's byte frame.
// ----------------------------------------------------------------------------
module prec_encode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          edit_cmd,
    input  logic [15:0]         target_addr,
    input  logic [7:0]          new_byte,
    input  logic [7:0]          group_len,
    output logic                frame_vld,
    output prec_pkg::frame_t    frame,
    input  logic                ser_ready
);

    logic              frame_vld_reg, frame_vld_next;
    prec_pkg::frame_t  frame_reg, frame_next;
    logic [15:0]       prev_addr_reg, prev_addr_next;
    logic [7:0]        pend_reg, pend_next;
    logic [15:0]       delta;
    logic              is_short;
    logic              start;
    logic              take;
    logic              accept;

    assign take     = frame_vld_reg && ser_ready;
    assign in_ready = !frame_vld_reg || take;
    assign accept   = in_valid && in_ready;
    assign delta    = target_addr - prev_addr_reg;
    assign is_short = (delta[15:6] == 10'd0);
    assign start    = (group_len != 8'd0);

    always_comb
    begin
        frame_next.data = '0;
        frame_next.cnt  = '0;
        pend_next       = pend_reg - 8'd1;
        if (pend_reg == 8'd0)
        begin
            pend_next = start ? (group_len - 8'd1) : 8'd0;
            if (is_short)
            begin
                if (start)
                begin
                    frame_next.data[0] = {prec_pkg::HDR_LONG_CODE, prec_pkg::HDR_LONG_CODE,
                                          edit_cmd, 2'b00};
                    frame_next.data[1] = group_len;
                    frame_next.data[2] = {2'b00, delta[5:0]};
                    frame_next.cnt     = 3'd3;
                end
                else
                begin
                    frame_next.data[0] = {edit_cmd, delta[5:0]};
                    frame_next.cnt     = 3'd1;
                end
            end
            else
            begin
                if (start)
                begin
                    frame_next.data[0] = {prec_pkg::HDR_LONG_CODE, prec_pkg::HDR_LONG_CODE,
                                          prec_pkg::HDR_LONG_CODE, edit_cmd};
                    frame_next.data[1] = group_len;
                    frame_next.data[2] = delta[15:8];
                    frame_next.data[3] = delta[7:0];
                    frame_next.cnt     = 3'd4;
                end
                else
                begin
                    frame_next.data[0] = {prec_pkg::HDR_LONG_CODE, edit_cmd, 4'b0000};
                    frame_next.data[1] = delta[15:8];
                    frame_next.data[2] = delta[7:0];
                    frame_next.cnt     = 3'd3;
                end
            end
        end
        if (edit_cmd == prec_pkg::CMD_INSERT || edit_cmd == prec_pkg::CMD_SUBST)
        begin
            frame_next.data[frame_next.cnt] = new_byte;
            frame_next.cnt                  = frame_next.cnt + 3'd1;
        end
    end

    always_comb
    begin
        prev_addr_next = prev_addr_reg;
        frame_vld_next = frame_vld_reg;
        if (take)
            frame_vld_next = 1'b0;
        if (accept)
        begin
            prev_addr_next = target_addr;
            frame_vld_next = (frame_next.cnt != 3'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_vld_reg <= 1'b0;
            prev_addr_reg <= 16'd0;
            pend_reg      <= 8'd0;
        end
        else
        begin
            frame_vld_reg <= frame_vld_next;
            prev_addr_reg <= prev_addr_next;
            if (accept)
                pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            frame_reg <= frame_next;
    end

    assign frame_vld = frame_vld_reg;
    assign frame     = frame_reg;

endmodule

/* rtl/prec_serialize.sv */
// ----------------------------------------------------------------------------
// Patch record serializer
// Holds one frame and sends its bytes one beat at a time.
// ----------------------------------------------------------------------------
module prec_serialize
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_vld,
    input  prec_pkg::frame_t    frame,
    output logic                ser_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last_of_item
);

    logic              busy_reg, busy_next;
    prec_pkg::cnt_t    idx_reg, idx_next;
    prec_pkg::frame_t  buf_reg;
    logic              load;

    assign last_of_item = (idx_reg == (buf_reg.cnt - 3'd1));
    assign out_valid    = busy_reg;
    assign out_byte     = buf_reg.data[idx_reg];
    assign ser_ready    = !busy_reg || (out_ready && last_of_item);
    assign load         = frame_vld && ser_ready;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (busy_reg && out_ready)
        begin
            if (last_of_item)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= frame;
    end

endmodule

/* tb/prec_stream_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Patch record encoder stream checker
// Watches both channels of the encoder. Every accepted record is encoded
// into the bytes it must produce. Every output beat is compared with the
// oldest byte still owed. Failures and the number of owed bytes go to the
// top.
// ----------------------------------------------------------------------------
module prec_stream_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  edit_cmd,
    input  logic [15:0] target_addr,
    input  logic [7:0]  new_byte,
    input  logic [7:0]  group_len,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        last_of_item,
    output int          failures,
    output int          owed_bytes
);

    localparam logic [15:0] SHORT_MAX_DELTA = 16'd63;

    typedef struct {
        prec_pkg::byte_t data;
        logic            last;
    } enc_beat_t;

    enc_beat_t   owed_q[$];
    logic [15:0] last_addr;
    logic [7:0]  members_left;
    int          fail_tally;
    int          owed_tally;

    assign failures   = fail_tally;
    assign owed_bytes = owed_tally;

    function automatic void encode_record(input logic [1:0] cmd, input logic [15:0] addr,
                                          input logic [7:0] data, input logic [7:0] glen);
        logic [15:0]     delta;
        prec_pkg::byte_t frame[$];
        delta = addr - last_addr;
        if (members_left == 8'd0)
        begin
            if (delta <= SHORT_MAX_DELTA)
            begin
                if (glen != 8'd0)
                begin
                    members_left = glen - 8'd1;
                    frame.push_back({prec_pkg::HDR_LONG_CODE, prec_pkg::HDR_LONG_CODE,
                                     cmd, 2'b00});
                    frame.push_back(glen);
                    frame.push_back(delta[7:0]);
                end
                else
                begin
                    frame.push_back({cmd, delta[5:0]});
                end
            end
            else
            begin
                if (glen != 8'd0)
                begin
                    members_left = glen - 8'd1;
                    frame.push_back({prec_pkg::HDR_LONG_CODE, prec_pkg::HDR_LONG_CODE,
                                     prec_pkg::HDR_LONG_CODE, cmd});
                    frame.push_back(glen);
                end
                else
                begin
                    frame.push_back({prec_pkg::HDR_LONG_CODE, cmd, 4'b0000});
                end
                frame.push_back(delta[15:8]);
                frame.push_back(delta[7:0]);
            end
        end
        else
        begin
            members_left = members_left - 8'd1;
        end
        if (cmd == prec_pkg::CMD_INSERT || cmd == prec_pkg::CMD_SUBST)
            frame.push_back(data);
        foreach (frame[i])
            owed_q.push_back('{data: frame[i], last: (i == frame.size() - 1)});
        last_addr = addr;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        enc_beat_t exp_beat;
        if (!rst_n)
        begin
            owed_q.delete();
            last_addr    = 16'd0;
            members_left = 8'd0;
            fail_tally   = 0;
            owed_tally   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                encode_record(edit_cmd, target_addr, new_byte, group_len);
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("unexpected beat: out_byte %0h, last_of_item %0b",
                           out_byte, last_of_item);
                    fail_tally++;
                end
                else
                begin
                    exp_beat = owed_q.pop_front();
                    if (out_byte !== exp_beat.data)
                    begin
                        $error("out_byte mismatch: expected %0h, actual %0h",
                               exp_beat.data, out_byte);
                        fail_tally++;
                    end
                    if (last_of_item !== exp_beat.last)
                    begin
                        $error("last_of_item mismatch: expected %0b, actual %0b",
                               exp_beat.last, last_of_item);
                        fail_tally++;
                    end
                end
            end
            owed_tally = owed_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Patch record encoder testbench
// Drives directed edit records, then random record streams with groups and
// address deltas around the short/long boundary, in bursts, while the byte
// receiver stalls on a changing pattern. Checking is done by the stream
// checker; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     RANDOM_RECORDS = 470;
    localparam int     CYCLE_LIMIT    = 300000;
    localparam int     DRAIN_CYCLES   = 8;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  edit_cmd = 2'd0;
    logic [15:0] target_addr = 16'd0;
    logic [7:0]  new_byte = 8'd0;
    logic [7:0]  group_len = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_item;

    int          failures;
    int          owed_bytes;
    int          cycle_cnt = 0;
    logic [15:0] stim_addr = 16'd0;

    int          rx_mode = 0;
    int          rx_left = 0;
    int          rx_phase = 0;

    patch_record_byte_encoder_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .edit_cmd     (edit_cmd),
        .target_addr  (target_addr),
        .new_byte     (new_byte),
        .group_len    (group_len),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item)
    );

    prec_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .edit_cmd     (edit_cmd),
        .target_addr  (target_addr),
        .new_byte     (new_byte),
        .group_len    (group_len),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .failures     (failures),
        .owed_bytes   (owed_bytes)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: full speed, light stalls, heavy stalls, or one beat in four
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 150);
        end
        else
        begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (rx_phase % 4 == 0);
        endcase
    end

    task automatic send_rec(input logic [1:0] cmd, input logic [15:0] addr,
                            input logic [7:0] data, input logic [7:0] glen);
        @(negedge clk);
        in_valid    <= 1'b1;
        edit_cmd    <= cmd;
        target_addr <= addr;
        new_byte    <= data;
        group_len   <= glen;
        stim_addr    = addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_bytes != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic send_random_rec();
        logic [1:0]  cmd;
        logic [15:0] delta;
        logic [7:0]  glen;
        int          pick;
        pick = $urandom_range(0, 15);
        cmd  = (pick == 0) ? CMD_RSVD : 2'(pick % 3);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            delta = 16'($urandom_range(0, 63));
        else if (pick == 4)
            delta = $urandom_range(0, 1) ? 16'd63 : 16'd64;
        else if (pick == 5)
            delta = 16'($urandom_range(65472, 65535));
        else
            delta = 16'($urandom);
        pick = $urandom_range(0, 63);
        if (pick < 40)
            glen = 8'd0;
        else if (pick < 62)
            glen = 8'($urandom_range(1, 6));
        else if (pick == 62)
            glen = 8'($urandom_range(7, 40));
        else
            glen = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(41, 254));
        send_rec(cmd, stim_addr + delta, 8'($urandom), glen);
    endtask

    initial
    begin
        int sent;
        int burst;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(negedge clk);

        // directed records
        send_rec(prec_pkg::CMD_INSERT, 16'h0000, 8'hFF, 8'd0);
        send_rec(prec_pkg::CMD_SUBST,  16'h003F, 8'h00, 8'd0);
        send_rec(prec_pkg::CMD_DELETE, 16'h007F, 8'h12, 8'd0);
        send_rec(CMD_RSVD,             16'h007E, 8'h34, 8'd0);
        idle_cycles(3);
        send_rec(prec_pkg::CMD_INSERT, 16'h0082, 8'hA5, 8'd3);
        send_rec(prec_pkg::CMD_DELETE, 16'h0083, 8'h77, 8'd0);
        send_rec(prec_pkg::CMD_SUBST,  16'h000A, 8'h3C, 8'd7);
        send_rec(prec_pkg::CMD_SUBST,  16'hFFFF, 8'h5A, 8'd1);
        send_rec(prec_pkg::CMD_INSERT, 16'h0000, 8'hC3, 8'd0);
        idle_cycles(1);
        send_rec(CMD_RSVD,             16'h0028, 8'hEE, 8'd2);
        send_rec(CMD_RSVD,             16'h0028, 8'h11, 8'd0);
        send_rec(prec_pkg::CMD_DELETE, 16'h8000, 8'h99, 8'd2);
        send_rec(prec_pkg::CMD_INSERT, 16'h7FFF, 8'hFF, 8'd0);
        send_rec(prec_pkg::CMD_DELETE, 16'h7FFF, 8'h00, 8'd0);
        send_rec(prec_pkg::CMD_SUBST,  16'h803E, 8'h81, 8'd255);
        send_rec(prec_pkg::CMD_INSERT, 16'h803F, 8'h7E, 8'd4);
        send_rec(prec_pkg::CMD_DELETE, 16'h0000, 8'h42, 8'd0);
        send_rec(prec_pkg::CMD_SUBST,  16'hFFC0, 8'h24, 8'd0);
        wait_drained();

        // random record streams in bursts
        sent = 0;
        while (sent < RANDOM_RECORDS)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                send_random_rec();
                sent++;
                if (sent % 150 == 0)
                    wait_drained();
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 12));
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
